// File: design/tlg_pkg.sv
// Package for the toroidal life grid: action codes, rule constants, datapath
// command struct and select codes. No dependencies.
package tlg_pkg;

   localparam int GRID_WIDTH_DEF  = 64;
   localparam int GRID_HEIGHT_DEF = 64;

   // Input word field widths
   localparam int ACTION_W  = 2;
   localparam int COORD_W   = 6;
   localparam int COUNT_W   = 4;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 8;

   // Action codes
   localparam logic [ACTION_W-1:0] ACT_WRITE   = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_READ    = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_ADVANCE = 2'd2;

   // B3/S23 rule
   localparam logic [COUNT_W-1:0] BORN_COUNT   = 4'd3;
   localparam logic [COUNT_W-1:0] SURVIVE_LOW  = 4'd2;
   localparam logic [COUNT_W-1:0] SURVIVE_HIGH = 4'd3;

   // Read address select
   localparam logic [1:0] RD_SWEEP = 2'd0;
   localparam logic [1:0] RD_UP    = 2'd1;
   localparam logic [1:0] RD_MID   = 2'd2;
   localparam logic [1:0] RD_DOWN  = 2'd3;

   // Write source select
   localparam logic [1:0] WR_ZERO = 2'd0;
   localparam logic [1:0] WR_NEXT = 2'd1;
   localparam logic [1:0] WR_CELL = 2'd2;

   typedef struct packed {
      logic       capture;      // latch request payload
      logic       rd_en;
      logic [1:0] rd_src;
      logic       shift;        // advance the three-row window
      logic       shift_first;  // shift saved row 0 instead of memory data
      logic       save_first;   // keep old row 0 for the wrap at the bottom
      logic       wr_en;
      logic [1:0] wr_src;
      logic       apply_write;  // patch addressed cell into middle row
      logic       load_rsp;
      logic       rsp_zero;
   } tlg_cmd_type;

endpackage

// File: design/tlg_datapath.sv
// Datapath of the toroidal life grid: row memory, three-row window, next
// generation lanes, cell count and result register. Depends on tlg_pkg.
module tlg_datapath #(
   parameter int GRID_WIDTH  = tlg_pkg::GRID_WIDTH_DEF,
   parameter int GRID_HEIGHT = tlg_pkg::GRID_HEIGHT_DEF,
   parameter int COL_W       = $clog2(GRID_WIDTH),
   parameter int ROW_W       = $clog2(GRID_HEIGHT)
) (
   input  logic                          clock,
   input  tlg_pkg::tlg_cmd_type          cmd,
   input  logic [ROW_W-1:0]              rd_row,
   input  logic [ROW_W-1:0]              wr_row,
   input  logic [tlg_pkg::COORD_W-1:0]   req_column,
   input  logic [tlg_pkg::COORD_W-1:0]   req_row,
   input  logic                          req_write_value,
   output logic                          rsp_cell_value,
   output logic [tlg_pkg::COUNT_W-1:0]   rsp_neighbor_count
);
   import tlg_pkg::*;

   localparam int COORD_N = 2 ** COORD_W;

   logic [GRID_WIDTH-1:0] mem [GRID_HEIGHT];
   logic [GRID_WIDTH-1:0] mem_q_ff;

   logic [GRID_WIDTH-1:0] prev_ff, cur_ff, next_ff, first_ff;
   logic [GRID_WIDTH-1:0] cur_mod, next_gen, wr_data;
   logic [COL_W-1:0]      col_ff, col_l, col_r;
   logic [ROW_W-1:0]      row_ff, row_up, row_dn, rd_addr, wr_addr;
   logic                  wv_ff;
   logic                  cell_ff;
   logic [COUNT_W-1:0]    count_ff, count;

   logic [COL_W-1:0] col_tab [COORD_N];
   logic [ROW_W-1:0] row_tab [COORD_N];

   // Reduce incoming coordinates modulo the grid size
   for (genvar i = 0; i < COORD_N; i++) begin : g_mod_tab
      assign col_tab[i] = COL_W'(i % GRID_WIDTH);
      assign row_tab[i] = ROW_W'(i % GRID_HEIGHT);
   end

   assign row_up = (row_ff == '0) ? ROW_W'(GRID_HEIGHT - 1) : row_ff - 1'b1;
   assign row_dn = (row_ff == ROW_W'(GRID_HEIGHT - 1)) ? '0 : row_ff + 1'b1;
   assign col_l  = (col_ff == '0) ? COL_W'(GRID_WIDTH - 1) : col_ff - 1'b1;
   assign col_r  = (col_ff == COL_W'(GRID_WIDTH - 1)) ? '0 : col_ff + 1'b1;

   always_comb begin
      unique case (cmd.rd_src)
         RD_SWEEP: rd_addr = rd_row;
         RD_UP:    rd_addr = row_up;
         RD_MID:   rd_addr = row_ff;
         RD_DOWN:  rd_addr = row_dn;
      endcase
   end

   always_comb begin
      cur_mod = cur_ff;
      cur_mod[col_ff] = wv_ff;
   end

   // One lane per column, all from the old window
   always_comb begin
      int         xl;
      int         xr;
      logic [3:0] n;
      next_gen = '0;
      for (int x = 0; x < GRID_WIDTH; x++) begin
         xl = (x == 0) ? GRID_WIDTH - 1 : x - 1;
         xr = (x == GRID_WIDTH - 1) ? 0 : x + 1;
         n = 4'(prev_ff[xl]) + 4'(prev_ff[x]) + 4'(prev_ff[xr])
           + 4'(cur_ff[xl]) + 4'(cur_ff[xr])
           + 4'(next_ff[xl]) + 4'(next_ff[x]) + 4'(next_ff[xr]);
         next_gen[x] = cur_ff[x] ? (n >= SURVIVE_LOW && n <= SURVIVE_HIGH)
                                 : (n == BORN_COUNT);
      end
   end

   always_comb begin
      unique case (cmd.wr_src)
         WR_NEXT: begin
            wr_addr = wr_row;
            wr_data = next_gen;
         end
         WR_CELL: begin
            wr_addr = row_ff;
            wr_data = cur_mod;
         end
         default: begin
            wr_addr = wr_row;
            wr_data = '0;
         end
      endcase
   end

   assign count = 4'(prev_ff[col_l]) + 4'(prev_ff[col_ff]) + 4'(prev_ff[col_r])
                + 4'(cur_ff[col_l]) + 4'(cur_ff[col_r])
                + 4'(next_ff[col_l]) + 4'(next_ff[col_ff]) + 4'(next_ff[col_r]);

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         mem_q_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         col_ff <= col_tab[req_column];
         row_ff <= row_tab[req_row];
         wv_ff  <= req_write_value;
      end
      if (cmd.save_first) begin
         first_ff <= mem_q_ff;
      end
      if (cmd.shift) begin
         prev_ff <= cur_ff;
         cur_ff  <= next_ff;
         next_ff <= cmd.shift_first ? first_ff : mem_q_ff;
      end else if (cmd.apply_write) begin
         cur_ff <= cur_mod;
      end
      if (cmd.load_rsp) begin
         cell_ff  <= cmd.rsp_zero ? 1'b0 : cur_ff[col_ff];
         count_ff <= cmd.rsp_zero ? '0 : count;
      end
   end

   assign rsp_cell_value     = cell_ff;
   assign rsp_neighbor_count = count_ff;

endmodule

// File: design/tlg_ctrl.sv
// Controller of the toroidal life grid: clearing pass, cell and generation
// sequences, result handshake. Depends on tlg_pkg.
module tlg_ctrl #(
   parameter int GRID_HEIGHT = tlg_pkg::GRID_HEIGHT_DEF,
   parameter int ROW_W       = $clog2(GRID_HEIGHT)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [tlg_pkg::ACTION_W-1:0]  req_action,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output tlg_pkg::tlg_cmd_type          cmd,
   output logic [ROW_W-1:0]              rd_row,
   output logic [ROW_W-1:0]              wr_row
);
   import tlg_pkg::*;

   localparam int K_W = $clog2(GRID_HEIGHT + 4);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_CELL  = 3'd2;
   localparam logic [2:0] ST_ADV   = 3'd3;
   localparam logic [2:0] ST_FIN   = 3'd4;

   logic [2:0]          st_ff, st_in;
   logic [K_W-1:0]      k_ff, k_in;
   logic [ACTION_W-1:0] act_ff, act_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                req_accept;

   assign req_tready = (st_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      st_in  = st_ff;
      k_in   = k_ff + 1'b1;
      act_in = act_ff;
      cmd    = '0;
      rd_row = '0;
      wr_row = '0;
      unique case (st_ff)
         ST_CLEAR: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_src = WR_ZERO;
            wr_row     = ROW_W'(k_ff);
            if (k_ff == K_W'(GRID_HEIGHT - 1)) begin
               st_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            k_in = '0;
            if (req_accept) begin
               cmd.capture = 1'b1;
               act_in      = req_action;
               if (req_action == ACT_ADVANCE) begin
                  st_in = ST_ADV;
               end else if (req_action == ACT_READ || req_action == ACT_WRITE) begin
                  st_in = ST_CELL;
               end else begin
                  st_in = ST_FIN;
               end
            end
         end
         ST_CELL: begin
            // read rows above, at and below, then patch the middle row on a write
            cmd.rd_en = (k_ff <= K_W'(2));
            if (k_ff == K_W'(0)) begin
               cmd.rd_src = RD_UP;
            end else if (k_ff == K_W'(1)) begin
               cmd.rd_src = RD_MID;
            end else begin
               cmd.rd_src = RD_DOWN;
            end
            cmd.shift = (k_ff >= K_W'(1)) && (k_ff <= K_W'(3));
            if (k_ff == K_W'(4)) begin
               cmd.apply_write = (act_ff == ACT_WRITE);
               cmd.wr_en       = (act_ff == ACT_WRITE);
               cmd.wr_src      = WR_CELL;
               st_in           = ST_FIN;
            end
         end
         ST_ADV: begin
            // read order: last row, then rows 0 up to the last row again
            cmd.rd_en      = (k_ff <= K_W'(GRID_HEIGHT));
            cmd.rd_src     = RD_SWEEP;
            rd_row         = (k_ff == '0) ? ROW_W'(GRID_HEIGHT - 1) : ROW_W'(k_ff - 1'b1);
            cmd.save_first = (k_ff == K_W'(2));
            cmd.shift      = (k_ff >= K_W'(1)) && (k_ff <= K_W'(GRID_HEIGHT + 2));
            cmd.shift_first = (k_ff == K_W'(GRID_HEIGHT + 2));
            cmd.wr_en      = (k_ff >= K_W'(4));
            cmd.wr_src     = WR_NEXT;
            wr_row         = ROW_W'(k_ff - K_W'(4));
            if (k_ff == K_W'(GRID_HEIGHT + 3)) begin
               st_in = ST_FIN;
            end
         end
         ST_FIN: begin
            // hold until the output register is free
            cmd.rsp_zero = !(act_ff == ACT_READ || act_ff == ACT_WRITE);
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.load_rsp = 1'b1;
               st_in        = ST_IDLE;
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_CLEAR;
         k_ff         <= '0;
         act_ff       <= ACT_WRITE;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         k_ff         <= k_in;
         act_ff       <= act_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_valid_ff || rsp_tready))
      else $error("result loaded over an untaken word");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |=> rsp_valid_ff)
      else $error("loaded result not presented");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (st_ff != ST_IDLE))
      else $error("accepted word did not start a sequence");

   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_CLEAR) |-> (!req_tready && cmd.wr_en))
      else $error("clearing pass not exclusive");

   a_rise_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(st_ff) == ST_FIN))
      else $error("result raised outside the finish step");

endmodule

// File: design/toroidal_life_grid_top.sv
// Top level of the toroidal life grid: request/response stream ports around
// the controller and datapath. Depends on tlg_pkg, tlg_ctrl, tlg_datapath.

// Holds a GRID_WIDTH x GRID_HEIGHT torus of one-bit cells (rule B3/S23).
// After reset a clearing pass writes every row to zero, during which
// req_tready stays low. Each request word writes a cell, reads a cell, or
// advances one generation, and gives exactly one response word with the
// addressed cell and its live neighbour count (zeros for advance and for the
// unused action). A cell read or write reads the three rows around the cell
// one per cycle through the single read port of the row memory. An advance
// streams the rows through a three-row window, one row read and one new row
// written per cycle. Coordinates are reduced modulo the grid size. A new
// request is taken while an earlier response still waits.
module toroidal_life_grid_top #(
   parameter int GRID_WIDTH  = tlg_pkg::GRID_WIDTH_DEF,
   parameter int GRID_HEIGHT = tlg_pkg::GRID_HEIGHT_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [1:0] action, [7:2] column, [13:8] row, [14] write_value, [15] zero
   input  logic [tlg_pkg::REQ_DATA_W-1:0]  req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [0] cell_value, [4:1] neighbor_count, [7:5] zero
   output logic [tlg_pkg::RSP_DATA_W-1:0]  rsp_tdata
);
   import tlg_pkg::*;

   localparam int COL_W = $clog2(GRID_WIDTH);
   localparam int ROW_W = $clog2(GRID_HEIGHT);

   tlg_cmd_type        cmd;
   logic [ROW_W-1:0]   rd_row, wr_row;
   logic               cell_value;
   logic [COUNT_W-1:0] neighbor_count;

   tlg_ctrl #(
      .GRID_HEIGHT (GRID_HEIGHT),
      .ROW_W       (ROW_W)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_action (req_tdata[1:0]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .rd_row     (rd_row),
      .wr_row     (wr_row)
   );

   tlg_datapath #(
      .GRID_WIDTH  (GRID_WIDTH),
      .GRID_HEIGHT (GRID_HEIGHT),
      .COL_W       (COL_W),
      .ROW_W       (ROW_W)
   ) u_datapath (
      .clock              (clock),
      .cmd                (cmd),
      .rd_row             (rd_row),
      .wr_row             (wr_row),
      .req_column         (req_tdata[7:2]),
      .req_row            (req_tdata[13:8]),
      .req_write_value    (req_tdata[14]),
      .rsp_cell_value     (cell_value),
      .rsp_neighbor_count (neighbor_count)
   );

   assign rsp_tdata = {3'b000, neighbor_count, cell_value};

endmodule
